>>> design/execute_argument_parser_top_macros.svh
// assertion macros shared by the execute argument parser modules
// no dependencies; included by the files that carry assertions
`ifndef EXECUTE_ARGUMENT_PARSER_TOP_MACROS_SVH
`define EXECUTE_ARGUMENT_PARSER_TOP_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define EAP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eap: same-cycle check failed");

// next-cycle implication, quiet while reset is high
`define EAP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eap: next-cycle check failed");

`endif

>>> design/eap_pkg.sv
// types, character codes and helpers for the execute argument parser
// no dependencies; used by eap_fsm and execute_argument_parser_top
package eap_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_FIRST        = 3'd0,
      PH_AFTER_DIGIT  = 3'd1,
      PH_EXPECT_QUOTE = 3'd2,
      PH_IN_VALUE     = 3'd3,
      PH_AFTER_QUOTE  = 3'd4,
      PH_AFTER_COMMA  = 3'd5,
      PH_DONE         = 3'd6,
      PH_ERROR        = 3'd7
   } phase_type;

   // character codes
   localparam logic [7:0] CH_COMMA   = 8'h2c;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_EQUALS  = 8'h3d;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] VAL_A_LO   = 8'h23;
   localparam logic [7:0] VAL_A_HI   = 8'h26;
   localparam logic [7:0] VAL_B_LO   = 8'h28;
   localparam logic [7:0] VAL_B_HI   = 8'h5b;
   localparam logic [7:0] VAL_C_LO   = 8'h5d;
   localparam logic [7:0] VAL_C_HI   = 8'h7e;

   localparam int unsigned DATA_W  = 8;
   localparam int unsigned INDEX_W = 4;

   // one input item
   typedef struct packed {
      logic              start_flag;
      logic              end_mark;
      logic [DATA_W-1:0] data_byte;
   } item_type;

   // one result item
   typedef struct packed {
      logic               arg_ready;
      logic [INDEX_W-1:0] arg_index;
      logic               arg_with_value;
      logic               value_byte_valid;
      logic [DATA_W-1:0]  value_out;
      logic               value_done;
      logic               payload_done;
      logic               parse_error;
   } result_type;

   // printable class allowed inside a quoted value
   function automatic logic is_value_byte(input logic [DATA_W-1:0] b);
      return (b == CH_BANG)
          || (b >= VAL_A_LO && b <= VAL_A_HI)
          || (b >= VAL_B_LO && b <= VAL_B_HI)
          || (b >= VAL_C_LO && b <= VAL_C_HI);
   endfunction

   function automatic logic is_digit(input logic [DATA_W-1:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

>>> design/eap_fsm.sv
// phase state machine and result decode of the execute argument parser
// depends on eap_pkg and execute_argument_parser_top_macros.svh
`include "execute_argument_parser_top_macros.svh"

module eap_fsm (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  eap_pkg::item_type   item,
   output eap_pkg::result_type result
);

   eap_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [eap_pkg::INDEX_W-1:0] arg_ff, arg_in, arg_cur;
   logic [eap_pkg::DATA_W-1:0]  b;
   logic                        eop;

   // a start flag restarts the parser before the item is handled
   assign phase_cur = item.start_flag ? eap_pkg::PH_FIRST : phase_ff;
   assign arg_cur   = item.start_flag ? '0 : arg_ff;
   assign b         = item.data_byte;
   assign eop       = item.end_mark;

   // next state
   always_comb begin
      phase_in = phase_cur;
      arg_in   = arg_cur;
      unique case (phase_cur)
         eap_pkg::PH_FIRST, eap_pkg::PH_AFTER_COMMA: begin
            if (eop) begin
               phase_in = (phase_cur == eap_pkg::PH_FIRST) ? eap_pkg::PH_DONE
                                                             : eap_pkg::PH_ERROR;
            end else if (eap_pkg::is_digit(b)) begin
               arg_in   = eap_pkg::INDEX_W'(b - eap_pkg::CH_ZERO);
               phase_in = eap_pkg::PH_AFTER_DIGIT;
            end else begin
               phase_in = eap_pkg::PH_ERROR;
            end
         end
         eap_pkg::PH_AFTER_DIGIT: begin
            if (eop) phase_in = eap_pkg::PH_DONE;
            else if (b == eap_pkg::CH_COMMA) phase_in = eap_pkg::PH_AFTER_COMMA;
            else if (b == eap_pkg::CH_EQUALS) phase_in = eap_pkg::PH_EXPECT_QUOTE;
            else phase_in = eap_pkg::PH_ERROR;
         end
         eap_pkg::PH_EXPECT_QUOTE: begin
            phase_in = (!eop && b == eap_pkg::CH_QUOTE) ? eap_pkg::PH_IN_VALUE
                                                        : eap_pkg::PH_ERROR;
         end
         eap_pkg::PH_IN_VALUE: begin
            if (eop) phase_in = eap_pkg::PH_ERROR;
            else if (eap_pkg::is_value_byte(b)) phase_in = eap_pkg::PH_IN_VALUE;
            else if (b == eap_pkg::CH_QUOTE) phase_in = eap_pkg::PH_AFTER_QUOTE;
            else phase_in = eap_pkg::PH_ERROR;
         end
         eap_pkg::PH_AFTER_QUOTE: begin
            if (eop) phase_in = eap_pkg::PH_DONE;
            else if (b == eap_pkg::CH_COMMA) phase_in = eap_pkg::PH_AFTER_COMMA;
            else phase_in = eap_pkg::PH_ERROR;
         end
         eap_pkg::PH_DONE: phase_in = eap_pkg::PH_DONE;
         default:          phase_in = eap_pkg::PH_ERROR;
      endcase
   end

   // result decode
   always_comb begin
      result = '0;
      unique case (phase_cur)
         eap_pkg::PH_AFTER_DIGIT: begin
            if (eop || b == eap_pkg::CH_COMMA) begin
               result.arg_ready = 1'b1;
               result.arg_index = arg_cur;
            end
         end
         eap_pkg::PH_EXPECT_QUOTE: begin
            if (!eop && b == eap_pkg::CH_QUOTE) begin
               result.arg_ready      = 1'b1;
               result.arg_index      = arg_cur;
               result.arg_with_value = 1'b1;
            end
         end
         eap_pkg::PH_IN_VALUE: begin
            if (!eop && eap_pkg::is_value_byte(b)) begin
               result.value_byte_valid = 1'b1;
               result.value_out        = b;
            end else if (!eop && b == eap_pkg::CH_QUOTE) begin
               result.value_done = 1'b1;
            end
         end
         default: begin
            result.arg_ready = 1'b0;
         end
      endcase
      result.payload_done = (phase_in == eap_pkg::PH_DONE);
      result.parse_error  = (phase_in == eap_pkg::PH_ERROR);
   end

   // state registers, advanced once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= eap_pkg::PH_FIRST;
         arg_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         arg_ff   <= arg_in;
      end
   end

   // sticky end states hold until a start flag
   `EAP_ASSERT_NEXT(a_done_sticky, clock, reset,
      phase_ff == eap_pkg::PH_DONE && !(step_en && item.start_flag),
      phase_ff == eap_pkg::PH_DONE)
   `EAP_ASSERT_NEXT(a_error_sticky, clock, reset,
      phase_ff == eap_pkg::PH_ERROR && !(step_en && item.start_flag),
      phase_ff == eap_pkg::PH_ERROR)
   // argument index only ever holds a decimal digit
   `EAP_ASSERT_NOW(a_arg_digit, clock, reset, 1'b1, arg_ff <= 4'd9)

endmodule

>>> design/execute_argument_parser_top.sv
// Execute-payload argument parser: takes one payload byte or end mark per item
// and returns one result item for each. Throughput is one item per cycle while
// results are taken; an input register is followed by the result register,
// with the phase state machine in eap_fsm between them. A result waiting in
// the output register does not block the input as long as it is taken.
// depends on eap_pkg, eap_fsm and execute_argument_parser_top_macros.svh
`include "execute_argument_parser_top_macros.svh"

module execute_argument_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_flag
   input  logic        req_tlast,   // end_mark
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] arg_index, [11:4] value_out, [15:12] zero
   output logic [4:0]  rsp_tuser,   // [0] arg_ready, [1] arg_with_value,
                                    // [2] value_byte_valid, [3] value_done, [4] parse_error
   output logic        rsp_tlast    // payload_done
);

   logic                s1_valid_ff, s1_valid_in;
   eap_pkg::item_type   s1_item_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   eap_pkg::result_type rsp_ff, step_result;
   logic                out_free, s1_go, req_take;

   // handshake control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.start_flag <= req_tuser;
         s1_item_ff.end_mark   <= req_tlast;
         s1_item_ff.data_byte  <= req_tdata;
      end
   end

   // parser state machine
   eap_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_go),
      .item    (s1_item_ff),
      .result  (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_go) rsp_ff <= step_result;
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.value_out, rsp_ff.arg_index};
   assign rsp_tuser  = {rsp_ff.parse_error, rsp_ff.value_done, rsp_ff.value_byte_valid,
                        rsp_ff.arg_with_value, rsp_ff.arg_ready};
   assign rsp_tlast  = rsp_ff.payload_done;

   // a result is never both a correct end and an error
   `EAP_ASSERT_NOW(a_done_xor_err, clock, reset, rsp_tvalid, !(rsp_tlast && rsp_tuser[4]))
   // a value flag comes only with an argument report
   `EAP_ASSERT_NOW(a_withval_ready, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0])
   // a held input item is never dropped while the output is stalled
   `EAP_ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff)

endmodule

>>> tb/tb_execute_argument_parser_top.sv
// self-checking testbench for the execute argument parser top level
// uses eap_pkg for phase codes, character codes and the item structs
module tb_execute_argument_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1450;
   localparam int IDLE_PCT    = 15;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_TAIL  = 8;

   localparam eap_pkg::result_type R_NONE = '0;

   // one directed stimulus row, optionally with a typed-in result
   typedef struct {
      eap_pkg::item_type   in;
      bit                  typed;
      eap_pkg::result_type r;
   } row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] data_byte
   logic        req_tuser  = 1'b0; // [0] start_flag
   logic        req_tlast  = 1'b0; // end_mark
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [3:0] arg_index, [11:4] value_out, [15:12] zero
   logic [4:0]  rsp_tuser;         // [0] arg_ready, [1] arg_with_value,
                                   // [2] value_byte_valid, [3] value_done, [4] parse_error
   logic        rsp_tlast;         // payload_done

   // parser state mirrored by the predictor
   eap_pkg::phase_type model_phase = eap_pkg::PH_FIRST;
   logic [3:0]         model_arg   = '0;

   eap_pkg::result_type pending_results[$];
   bit                  cur_typed = 1'b0;
   eap_pkg::result_type cur_want  = '0;
   bit                  no_idle      = 1'b0;
   bit                  hold_request = 1'b0;

   int sent_items   = 0;
   int fail_count   = 0;
   int stall_cycles = 0;
   int payloads     = 0;
   int checked      = 0;
   int args_seen    = 0;
   int value_bytes  = 0;
   int value_closes = 0;
   int done_results = 0;
   int error_results = 0;

   string field_name [9] = '{"arg_ready", "arg_index", "arg_with_value",
                             "value_byte_valid", "value_out", "value_done",
                             "payload_done", "parse_error", "rsp_tdata_pad"};

   execute_argument_parser_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // build a result from its fields
   function automatic eap_pkg::result_type mk(input logic rdy, input logic [3:0] idx,
                                              input logic wv, input logic vv,
                                              input logic [7:0] vo, input logic vd,
                                              input logic pd, input logic er);
      eap_pkg::result_type r;
      r.arg_ready        = rdy;
      r.arg_index        = idx;
      r.arg_with_value   = wv;
      r.value_byte_valid = vv;
      r.value_out        = vo;
      r.value_done       = vd;
      r.payload_done     = pd;
      r.parse_error      = er;
      return r;
   endfunction

   // advance the parser mirror by one item and return its result
   function automatic eap_pkg::result_type parse_step(input eap_pkg::item_type it);
      eap_pkg::result_type r;
      logic                digit;
      logic                printable;
      logic [7:0]          b;
      r = '0;
      b = it.data_byte;
      digit = (b >= eap_pkg::CH_ZERO) && (b <= eap_pkg::CH_NINE);
      printable = (b == eap_pkg::CH_BANG)
               || (b >= eap_pkg::VAL_A_LO && b <= eap_pkg::VAL_A_HI)
               || (b >= eap_pkg::VAL_B_LO && b <= eap_pkg::VAL_B_HI)
               || (b >= eap_pkg::VAL_C_LO && b <= eap_pkg::VAL_C_HI);
      if (it.start_flag) begin
         model_phase = eap_pkg::PH_FIRST;
         model_arg   = '0;
      end
      case (model_phase)
         eap_pkg::PH_FIRST, eap_pkg::PH_AFTER_COMMA: begin
            if (it.end_mark) begin
               model_phase = (model_phase == eap_pkg::PH_FIRST) ? eap_pkg::PH_DONE
                                                                : eap_pkg::PH_ERROR;
            end else if (digit) begin
               model_arg   = b[3:0];
               model_phase = eap_pkg::PH_AFTER_DIGIT;
            end else begin
               model_phase = eap_pkg::PH_ERROR;
            end
         end
         eap_pkg::PH_AFTER_DIGIT: begin
            if (it.end_mark || b == eap_pkg::CH_COMMA) begin
               r.arg_ready = 1'b1;
               r.arg_index = model_arg;
               model_phase = it.end_mark ? eap_pkg::PH_DONE : eap_pkg::PH_AFTER_COMMA;
            end else if (b == eap_pkg::CH_EQUALS) begin
               model_phase = eap_pkg::PH_EXPECT_QUOTE;
            end else begin
               model_phase = eap_pkg::PH_ERROR;
            end
         end
         eap_pkg::PH_EXPECT_QUOTE: begin
            if (!it.end_mark && b == eap_pkg::CH_QUOTE) begin
               r.arg_ready      = 1'b1;
               r.arg_index      = model_arg;
               r.arg_with_value = 1'b1;
               model_phase      = eap_pkg::PH_IN_VALUE;
            end else begin
               model_phase = eap_pkg::PH_ERROR;
            end
         end
         eap_pkg::PH_IN_VALUE: begin
            if (it.end_mark) begin
               model_phase = eap_pkg::PH_ERROR;
            end else if (printable) begin
               r.value_byte_valid = 1'b1;
               r.value_out        = b;
            end else if (b == eap_pkg::CH_QUOTE) begin
               r.value_done = 1'b1;
               model_phase  = eap_pkg::PH_AFTER_QUOTE;
            end else begin
               model_phase = eap_pkg::PH_ERROR;
            end
         end
         eap_pkg::PH_AFTER_QUOTE: begin
            if (it.end_mark) model_phase = eap_pkg::PH_DONE;
            else if (b == eap_pkg::CH_COMMA) model_phase = eap_pkg::PH_AFTER_COMMA;
            else model_phase = eap_pkg::PH_ERROR;
         end
         eap_pkg::PH_DONE: begin
         end
         default: begin
            model_phase = eap_pkg::PH_ERROR;
         end
      endcase
      r.payload_done = (model_phase == eap_pkg::PH_DONE);
      r.parse_error  = (model_phase == eap_pkg::PH_ERROR);
      return r;
   endfunction

   // offer one item, with random idle cycles before it, until it is taken
   task automatic drive_item(input eap_pkg::item_type it, input bit typed,
                             input eap_pkg::result_type want);
      bit taken;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.start_flag;
      req_tlast  <= it.end_mark;
      req_tdata  <= it.data_byte;
      cur_typed = typed;
      cur_want  = want;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
         @(negedge clock);
      end
   endtask

   // input side: predict on every accepted item
   always @(posedge clock) begin : req_monitor
      eap_pkg::item_type   it;
      eap_pkg::result_type pred;
      if (!reset && req_tvalid && req_tready) begin
         it = eap_pkg::item_type'({req_tuser, req_tlast, req_tdata});
         sent_items++;
         pred = parse_step(it);
         pending_results.push_back(cur_typed ? cur_want : pred);
      end
   end

   // result side: compare each accepted item with the oldest expectation
   always @(posedge clock) begin : rsp_checker
      eap_pkg::result_type want;
      logic [7:0] w [9];
      logic [7:0] g [9];
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked++;
         if (pending_results.size() == 0) begin
            $error("result with no expectation waiting: tdata=%h tuser=%b tlast=%b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            w = '{8'(want.arg_ready), 8'(want.arg_index), 8'(want.arg_with_value),
                  8'(want.value_byte_valid), want.value_out, 8'(want.value_done),
                  8'(want.payload_done), 8'(want.parse_error), 8'h00};
            g = '{8'(rsp_tuser[0]), 8'(rsp_tdata[3:0]), 8'(rsp_tuser[1]),
                  8'(rsp_tuser[2]), rsp_tdata[11:4], 8'(rsp_tuser[3]), 8'(rsp_tlast),
                  8'(rsp_tuser[4]), 8'(rsp_tdata[15:12])};
            for (int i = 0; i < 9; i++) begin
               if (w[i] !== g[i]) begin
                  $error("%s mismatch: expected %h, actual %h", field_name[i], w[i], g[i]);
                  fail_count++;
               end
            end
         end
         if (rsp_tuser[0]) args_seen++;
         if (rsp_tuser[2]) value_bytes++;
         if (rsp_tuser[3]) value_closes++;
         if (rsp_tlast) done_results++;
         if (rsp_tuser[4]) error_results++;
      end
   end

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= !reset && (no_idle || $urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("execute_argument_parser_top regression: fail");
            $finish;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      row_type             dir_rows[$];
      eap_pkg::item_type   pl[$];
      logic [9:0]          raw;
      logic [7:0]          ch;
      int                  pick;
      int                  n_args;
      int                  len;
      int                  kind;
      int                  pos;

      dir_rows = '{
         // empty payload, then an ignored byte after the end
         '{eap_pkg::item_type'{1'b1, 1'b1, 8'h00}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0)},
         '{eap_pkg::item_type'{1'b0, 1'b0, 8'hff}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0)},
         // bare digit right before the end
         '{eap_pkg::item_type'{1'b1, 1'b0, eap_pkg::CH_NINE}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b1, 8'hff}, 1'b1,
           mk(1'b1, 4'd9, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0)},
         // quoted value with the class extremes, then a bare digit
         '{eap_pkg::item_type'{1'b1, 1'b0, eap_pkg::CH_ZERO}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_EQUALS}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_QUOTE}, 1'b1,
           mk(1'b1, 4'd0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0)},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_BANG}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b1, eap_pkg::CH_BANG, 1'b0, 1'b0, 1'b0)},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::VAL_C_HI}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b1, eap_pkg::VAL_C_HI, 1'b0, 1'b0, 1'b0)},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_QUOTE}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0)},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_COMMA}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, 8'h35}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_COMMA}, 1'b1,
           mk(1'b1, 4'd5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0)},
         // trailing comma, then the error sticks
         '{eap_pkg::item_type'{1'b0, 1'b1, 8'h00}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1)},
         '{eap_pkg::item_type'{1'b0, 1'b0, 8'h00}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1)},
         // equals with no quote after it
         '{eap_pkg::item_type'{1'b1, 1'b0, 8'h32}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_EQUALS}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, 8'h78}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1)},
         // byte outside the printable class inside a value
         '{eap_pkg::item_type'{1'b1, 1'b0, 8'h33}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_EQUALS}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_QUOTE}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::VAL_A_LO - 8'd1}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1)},
         // end inside a value
         '{eap_pkg::item_type'{1'b1, 1'b0, 8'h37}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_EQUALS}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_QUOTE}, 1'b0, R_NONE},
         '{eap_pkg::item_type'{1'b0, 1'b1, 8'h5a}, 1'b1,
           mk(1'b0, 4'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1)}
      };

      // reset
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) drive_item(dir_rows[i].in, dir_rows[i].typed, dir_rows[i].r);

      // random payloads: mostly well formed, some broken, some pure noise
      while (sent_items < ITEM_TARGET) begin
         payloads++;
         if (payloads == 30) hold_request = 1'b1;
         no_idle = (payloads >= 60 && payloads < 85);
         if (payloads == 100) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (pending_results.size() != 0) @(negedge clock);
         end
         pl.delete();
         pick = $urandom_range(99);
         if (pick >= 93) begin
            repeat ($urandom_range(1, 6)) begin
               raw = 10'($urandom_range(1023));
               pl.push_back(eap_pkg::item_type'(raw));
            end
         end else begin
            n_args = $urandom_range(0, 4);
            for (int a = 0; a < n_args; a++) begin
               if (a > 0) pl.push_back(eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_COMMA});
               pl.push_back(eap_pkg::item_type'{1'b0, 1'b0,
                                                8'(eap_pkg::CH_ZERO + $urandom_range(0, 9))});
               if ($urandom_range(1)) begin
                  pl.push_back(eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_EQUALS});
                  pl.push_back(eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_QUOTE});
                  len = $urandom_range(0, 6);
                  repeat (len) begin
                     // skip the three holes in the printable range
                     do ch = 8'($urandom_range(eap_pkg::CH_BANG, eap_pkg::VAL_C_HI));
                     while (ch == eap_pkg::VAL_A_LO - 8'd1 || ch == eap_pkg::CH_QUOTE
                            || ch == eap_pkg::VAL_C_LO - 8'd1);
                     pl.push_back(eap_pkg::item_type'{1'b0, 1'b0, ch});
                  end
                  pl.push_back(eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_QUOTE});
               end
            end
            pl.push_back(eap_pkg::item_type'{1'b0, 1'b1, 8'($urandom_range(255))});
            pl[0].start_flag = 1'b1;
            if (pick >= 80) begin
               kind = $urandom_range(0, 4);
               pos  = $urandom_range(0, pl.size() - 1);
               case (kind)
                  0: begin
                     pl[pos].data_byte = 8'($urandom_range(255));
                     pl[pos].end_mark  = 1'b0;
                  end
                  1: pl.insert(pl.size() - 1,
                               eap_pkg::item_type'{1'b0, 1'b0, eap_pkg::CH_COMMA});
                  2: if (pl.size() > 1) pl.delete(pl.size() - 1);
                  3: begin
                     pl[pos].end_mark = 1'b1;
                     while (pl.size() > pos + 1) pl.delete(pl.size() - 1);
                  end
                  default: begin
                     repeat ($urandom_range(1, 3)) begin
                        raw = 10'($urandom_range(511));
                        pl.push_back(eap_pkg::item_type'(raw));
                     end
                  end
               endcase
            end
         end
         foreach (pl[i]) drive_item(pl[i], 1'b0, R_NONE);
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then a short tail for stray results
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_TAIL) @(negedge clock);

      $display("covered %0d directed rows and %0d random payloads, %0d results checked",
               dir_rows.size(), payloads, checked);
      $display("seen %0d arguments, %0d value bytes, %0d closing quotes, %0d done, %0d error",
               args_seen, value_bytes, value_closes, done_results, error_results);
      if (fail_count == 0) begin
         $display("execute_argument_parser_top regression: pass");
      end else begin
         $display("execute_argument_parser_top regression: fail");
      end
      $finish;
   end

endmodule

>>> execute_argument_parser_top.f
+incdir+design
design/eap_pkg.sv
design/eap_fsm.sv
design/execute_argument_parser_top.sv
tb/tb_execute_argument_parser_top.sv
